// File: hw/rtl/dcas_pkg.sv
package dcas_pkg;

  localparam logic [63:0] BitsPosInf  = 64'h7FF0_0000_0000_0000;
  localparam logic [63:0] BitsNegInf  = 64'hFFF0_0000_0000_0000;
  localparam logic [63:0] BitsHighest = 64'h7FEF_FFFF_FFFF_FFFF;
  localparam logic [63:0] BitsLowest  = 64'hFFEF_FFFF_FFFF_FFFF;
  localparam logic [31:0] NaLowWord   = 32'd1954;

  typedef struct packed {
    logic [63:0] value_bits;
    logic        last;
  } in_item_t;

  typedef struct packed {
    logic [63:0] range_low;
    logic [63:0] range_high;
    logic        has_na;
    logic        not_whole;
    logic        has_nan;
    logic        pos_inf_seen;
    logic        neg_inf_seen;
    logic        lowest_seen;
    logic        highest_seen;
  } out_item_t;

  // a < b for finite doubles given as bits (+0 == -0)
  function automatic logic fp_less(logic [63:0] a, logic [63:0] b);
    logic a_zero;
    logic b_zero;
    a_zero = (a[62:0] == '0);
    b_zero = (b[62:0] == '0);
    if (a_zero && b_zero) return 1'b0;
    if (a[63] != b[63]) return a[63];
    if (a[63]) return a[62:0] > b[62:0];
    return a[62:0] < b[62:0];
  endfunction

  function automatic logic has_fraction(logic [63:0] b);
    logic [10:0] e;
    logic [51:0] mask;
    e = b[62:52];
    if (b[62:0] == '0) return 1'b0;
    if (e < 11'd1023) return 1'b1;
    if (e >= 11'd1075) return 1'b0;
    mask = 52'hF_FFFF_FFFF_FFFF >> (e - 11'd1023);
    return (b[51:0] & mask) != '0;
  endfunction

endpackage

// File: hw/rtl/dcas_stream_if.sv
interface dcas_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/double_column_attribute_scan.sv
// Column attribute scan: takes one binary64 element per cycle with a last mark and, on
// the last element, gives one summary item (NA/NaN/inf/extreme flags and min/max of
// non-NA values, forced to +inf/-inf when a NaN, infinity or fraction was seen). The
// result is valid in the cycle after the last element; a new element is accepted every
// cycle unless the result register holds an untaken item. Empty vectors give no result.
module double_column_attribute_scan (
  input  logic          clk_i,
  input  logic          rst_ni,
  dcas_stream_if.sink   in_i,
  dcas_stream_if.source out_o
);

  logic seen_na_q, seen_nan_q, seen_posinf_q, seen_neginf_q;
  logic seen_frac_q, seen_lowest_q, seen_highest_q;
  logic [63:0] min_q, max_q;
  dcas_pkg::out_item_t res_q, res_d;
  logic res_vld_q;

  logic [63:0] v;
  logic exp_all, mant_nz, is_nan, is_na, is_inf, is_fin;
  logic na_d, nan_d, pinf_d, ninf_d, frac_d, low_d, high_d, nonint;
  logic [63:0] min_d, max_d;
  logic acc;

  assign in_i.ready = !res_vld_q || out_o.ready;
  assign acc        = in_i.valid && in_i.ready;
  assign out_o.valid = res_vld_q;
  assign out_o.data  = res_q;

  always_comb begin
    v       = in_i.data.value_bits;
    exp_all = (v[62:52] == 11'h7FF);
    mant_nz = (v[51:0] != '0);
    is_nan  = exp_all && mant_nz;
    is_na   = is_nan && (v[31:0] == dcas_pkg::NaLowWord);
    is_inf  = exp_all && !mant_nz;
    is_fin  = !exp_all;
    na_d    = seen_na_q || is_na;
    nan_d   = seen_nan_q || (is_nan && !is_na);
    pinf_d  = seen_posinf_q || (is_inf && !v[63]);
    ninf_d  = seen_neginf_q || (is_inf && v[63]);
    frac_d  = seen_frac_q || (is_fin && dcas_pkg::has_fraction(v));
    low_d   = seen_lowest_q || (v == dcas_pkg::BitsLowest);
    high_d  = seen_highest_q || (v == dcas_pkg::BitsHighest);
    min_d   = min_q;
    max_d   = max_q;
    if (is_fin) begin
      if (!dcas_pkg::fp_less(min_q, v)) min_d = v;
      if (!dcas_pkg::fp_less(v, max_q)) max_d = v;
    end
    nonint = nan_d || pinf_d || ninf_d || frac_d;
    res_d.range_low    = nonint ? dcas_pkg::BitsPosInf : min_d;
    res_d.range_high   = nonint ? dcas_pkg::BitsNegInf : max_d;
    res_d.has_na       = na_d;
    res_d.not_whole    = nonint;
    res_d.has_nan      = nan_d;
    res_d.pos_inf_seen = pinf_d;
    res_d.neg_inf_seen = ninf_d;
    res_d.lowest_seen  = low_d;
    res_d.highest_seen = high_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_na_q <= 1'b0; seen_nan_q <= 1'b0; seen_posinf_q <= 1'b0;
      seen_neginf_q <= 1'b0; seen_frac_q <= 1'b0; seen_lowest_q <= 1'b0;
      seen_highest_q <= 1'b0;
      min_q <= dcas_pkg::BitsPosInf;
      max_q <= dcas_pkg::BitsNegInf;
      res_vld_q <= 1'b0;
    end else begin
      if (acc && in_i.data.last) res_vld_q <= 1'b1;
      else if (out_o.ready) res_vld_q <= 1'b0;
      if (acc) begin
        if (in_i.data.last) begin
          seen_na_q <= 1'b0; seen_nan_q <= 1'b0; seen_posinf_q <= 1'b0;
          seen_neginf_q <= 1'b0; seen_frac_q <= 1'b0; seen_lowest_q <= 1'b0;
          seen_highest_q <= 1'b0;
          min_q <= dcas_pkg::BitsPosInf;
          max_q <= dcas_pkg::BitsNegInf;
        end else begin
          seen_na_q <= na_d; seen_nan_q <= nan_d; seen_posinf_q <= pinf_d;
          seen_neginf_q <= ninf_d; seen_frac_q <= frac_d; seen_lowest_q <= low_d;
          seen_highest_q <= high_d;
          min_q <= min_d;
          max_q <= max_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && in_i.data.last) res_q <= res_d;
  end

endmodule

// File: sim/tb_double_column_attribute_scan.sv
module tb_double_column_attribute_scan;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 400000;

  logic clk_i;
  logic rst_ni;

  dcas_stream_if #(.T(dcas_pkg::in_item_t))  elem_if ();
  dcas_stream_if #(.T(dcas_pkg::out_item_t)) summ_if ();

  double_column_attribute_scan dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (elem_if.sink),
    .out_o  (summ_if.source)
  );

  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // scan state of the predictor
  logic                p_na, p_nan, p_pinf, p_ninf, p_frac, p_low, p_high;
  logic [63:0]         p_min, p_max;
  dcas_pkg::out_item_t summ_q[$];
  int unsigned         errors;
  int unsigned         cycles;
  logic                sink_en;

  function automatic logic frac_part(logic [63:0] b);
    int e;
    logic [63:0] mag;
    mag = {1'b0, b[62:0]};
    e = int'(b[62:52]) - 1023;
    if (mag == 0) return 1'b0;
    if (e < 0) return 1'b1;
    if (e >= 52) return 1'b0;
    return (mag & ((64'd1 << (52 - e)) - 64'd1)) != 0;
  endfunction

  function automatic logic dbl_lt(logic [63:0] a, logic [63:0] b);
    return $bitstoreal(a) < $bitstoreal(b);
  endfunction

  task automatic scan_clear();
    {p_na, p_nan, p_pinf, p_ninf, p_frac, p_low, p_high} = 7'd0;
    p_min = dcas_pkg::BitsPosInf;
    p_max = dcas_pkg::BitsNegInf;
  endtask

  function automatic dcas_pkg::out_item_t scan_element(logic [63:0] v, logic last);
    dcas_pkg::out_item_t r;
    logic ni;
    r = '0;
    if (v[62:52] == 11'h7FF && v[51:0] != 0) begin
      if (v[31:0] == dcas_pkg::NaLowWord) p_na = 1'b1;
      else p_nan = 1'b1;
    end else if (v[62:52] == 11'h7FF) begin
      if (v[63]) p_ninf = 1'b1;
      else p_pinf = 1'b1;
    end else begin
      if (frac_part(v)) p_frac = 1'b1;
      if (v == dcas_pkg::BitsLowest) p_low = 1'b1;
      if (v == dcas_pkg::BitsHighest) p_high = 1'b1;
      if (!dbl_lt(p_min, v)) p_min = v;
      if (!dbl_lt(v, p_max)) p_max = v;
    end
    if (last) begin
      ni = p_nan | p_pinf | p_ninf | p_frac;
      r.range_low    = ni ? dcas_pkg::BitsPosInf : p_min;
      r.range_high   = ni ? dcas_pkg::BitsNegInf : p_max;
      r.has_na       = p_na;
      r.not_whole    = ni;
      r.has_nan      = p_nan;
      r.pos_inf_seen = p_pinf;
      r.neg_inf_seen = p_ninf;
      r.lowest_seen  = p_low;
      r.highest_seen = p_high;
    end
    return r;
  endfunction

  // receiver: stall pattern and checking
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      summ_if.ready <= 1'b0;
      cycles <= 0;
    end else begin
      cycles <= cycles + 1;
      if (summ_if.valid && summ_if.ready) begin
        if (summ_q.size() == 0) begin
          $display("%0t: unexpected summary item %h", $time, summ_if.data);
          errors++;
        end else begin
          dcas_pkg::out_item_t e;
          e = summ_q.pop_front();
          if (e !== summ_if.data) begin
            $display("%0t: summary mismatch exp %h act %h", $time, e, summ_if.data);
            errors++;
          end
        end
      end
      summ_if.ready <= sink_en ? (cycles[5:3] != 3'd5 && $urandom_range(0, 3) != 0) : 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (cycles >= CycleLimit) begin
      $display("tb_double_column_attribute_scan NOT OK");
      $finish;
    end
  end

  // random element: small integers, with special patterns mixed in
  function automatic logic [63:0] rand_value();
    logic [63:0] v;
    case ($urandom_range(0, 11))
      0: v = {$urandom(), $urandom()};
      1: v = {$urandom_range(0, 1) == 1, 11'h7FF, 20'($urandom()),
              32'(dcas_pkg::NaLowWord)};
      2: v = {$urandom_range(0, 1) == 1, 11'h7FF, 20'($urandom() | 1), 32'($urandom())};
      3: v = $urandom_range(0, 1) ? dcas_pkg::BitsPosInf : dcas_pkg::BitsNegInf;
      4: v = $urandom_range(0, 1) ? dcas_pkg::BitsLowest : dcas_pkg::BitsHighest;
      5: v = {$urandom_range(0, 1) == 1, 63'd0};
      6: v = {$urandom_range(0, 1) == 1, 11'(1023 + $urandom_range(0, 60)),
              20'($urandom()), 32'($urandom())};
      default: v = $realtobits(real'($urandom_range(0, 2000)) - 1000.0);
    endcase
    return v;
  endfunction

  task automatic send_element(logic [63:0] v, logic last);
    dcas_pkg::out_item_t r;
    elem_if.valid <= 1'b1;
    elem_if.data  <= '{value_bits: v, last: last};
    do @(posedge clk_i); while (!elem_if.ready);
    r = scan_element(v, last);
    if (last) begin
      summ_q.push_back(r);
      scan_clear();
    end
  endtask

  typedef struct {
    logic [63:0]         v;
    logic                last;
    logic                check;
    dcas_pkg::out_item_t want;
  } dir_row_t;

  dir_row_t dir_rows[$];

  initial begin
    int unsigned burst;
    int unsigned len;
    int unsigned gap;
    dir_row_t row;
    errors = 0;
    sink_en = 1'b0;
    rst_ni = 1'b0;
    elem_if.valid = 1'b0;
    elem_if.data  = '0;
    scan_clear();
    // known at a glance: all-NA vector, lowest alone, highest alone, +inf alone, -inf alone
    dir_rows.push_back('{64'h7FF0_0000_0000_07A2, 1'b1, 1'b1,
      '{dcas_pkg::BitsPosInf, dcas_pkg::BitsNegInf,
        1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}});
    dir_rows.push_back('{dcas_pkg::BitsLowest, 1'b1, 1'b1,
      '{dcas_pkg::BitsLowest, dcas_pkg::BitsLowest,
        1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0}});
    dir_rows.push_back('{dcas_pkg::BitsHighest, 1'b1, 1'b1,
      '{dcas_pkg::BitsHighest, dcas_pkg::BitsHighest,
        1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1}});
    dir_rows.push_back('{dcas_pkg::BitsPosInf, 1'b1, 1'b1,
      '{dcas_pkg::BitsPosInf, dcas_pkg::BitsNegInf,
        1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0}});
    dir_rows.push_back('{dcas_pkg::BitsNegInf, 1'b1, 1'b1,
      '{dcas_pkg::BitsPosInf, dcas_pkg::BitsNegInf,
        1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0}});
    // zero ties, NaN, fraction, subnormal, all-ones, large integers, extremes, NA
    dir_rows.push_back('{64'h0, 1'b0, 1'b0, '0});
    dir_rows.push_back('{64'h8000_0000_0000_0000, 1'b0, 1'b0, '0});
    dir_rows.push_back('{64'h0, 1'b1, 1'b0, '0});
    dir_rows.push_back('{64'hFFF8_0000_0000_0000, 1'b0, 1'b0, '0});
    dir_rows.push_back('{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, '0});
    dir_rows.push_back('{64'h3FF8_0000_0000_0000, 1'b1, 1'b0, '0});
    dir_rows.push_back('{64'h0000_0000_0000_0001, 1'b1, 1'b0, '0});
    dir_rows.push_back('{64'h4330_0000_0000_0001, 1'b0, 1'b0, '0});
    dir_rows.push_back('{64'hC340_0000_0000_0000, 1'b0, 1'b0, '0});
    dir_rows.push_back('{dcas_pkg::BitsHighest, 1'b0, 1'b0, '0});
    dir_rows.push_back('{dcas_pkg::BitsLowest, 1'b0, 1'b0, '0});
    dir_rows.push_back('{64'hFFF0_0000_0000_07A2, 1'b1, 1'b0, '0});
    dir_rows.push_back('{64'h4000_0000_0000_0000, 1'b1, 1'b0, '0});
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      send_element(row.v, row.last);
      if (row.check) summ_q[summ_q.size() - 1] = row.want;
    end
    elem_if.valid <= 1'b0;
    sink_en = 1'b1;
    while (summ_q.size() != 0) @(posedge clk_i);
    // random vectors in bursts with gaps
    for (int n = 0; n < 1450; ) begin
      len = $urandom_range(1, $urandom_range(0, 7) == 0 ? 40 : 6);
      burst = $urandom_range(1, 12);
      for (int k = 0; k < len; k++) begin
        send_element(rand_value(), k == len - 1);
        n++;
        if (--burst == 0) begin
          gap = $urandom_range(0, 5);
          if (gap != 0) begin
            elem_if.valid <= 1'b0;
            repeat (gap) @(posedge clk_i);
          end
          burst = $urandom_range(1, 12);
        end
      end
      if (n > 700 && n < 760) begin
        elem_if.valid <= 1'b0;
        while (summ_q.size() != 0) @(posedge clk_i);
      end
    end
    elem_if.valid <= 1'b0;
    while (summ_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (errors == 0) $display("tb_double_column_attribute_scan OK");
    else $display("tb_double_column_attribute_scan NOT OK");
    $finish;
  end

endmodule
